/* rtl/first_fit_extent_allocator_macros.svh */
// assertion helpers for the extent allocator
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH

// clocked check, held off while in reset
`define FFEA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also runs during reset
`define FFEA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/ffea_pkg.sv */
package ffea_pkg;

    // operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;

    // result codes
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_NO_FIT  = 2'd1;
    localparam logic [1:0] STS_FULL    = 2'd2;
    localparam logic [1:0] STS_SKIPPED = 2'd3;

    // spare words tolerated before a split
    localparam int SPARE_WORDS = 2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] size_bytes;
        logic [31:0] address;
        logic [29:0] block_words;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] grant_addr;
        logic [29:0] grant_words;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_PREP2,
        ST_RD,
        ST_CHK,
        ST_DEC,
        ST_SH_RD,
        ST_SH_WR,
        ST_FIN,
        ST_DONE
    } state_t;

endpackage

/* rtl/ffea_ram.sv */
module ffea_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/first_fit_extent_allocator.sv */
// channel   direction  word                         handshake
// s_        in         ffea_pkg::req_t request      s_valid / s_ready
// m_        out        ffea_pkg::rsp_t result       m_valid / m_ready
// cfg_      in         32-bit floor address         cfg_valid / cfg_ready
//
// one request at a time; a table scan does a read and a check per extent visited,
// and an insert or removal shifts entries with a read and a write per entry moved,
// all through the extent RAM with its one write and one read port; the block
// passes through idle after each result word before it takes the next request
// synchronous active-low reset empties the table (count only, RAM keeps data)
// a finished result sits in the output register; the next request is taken
// meanwhile and only its own result waits for m_ready
`include "first_fit_extent_allocator_macros.svh"

module first_fit_extent_allocator #(
    parameter int MAX_EXTENTS = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ffea_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ffea_pkg::rsp_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [31:0]    cfg_data
);

    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);

    ffea_pkg::state_t state_reg, state_next;

    logic [31:0]    floor_reg;
    ffea_pkg::req_t req_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic           down_reg, down_next;
    logic [30:0]    want_reg, want_next;
    logic [29:0]    key_reg, key_next;
    logic [29:0]    klen_reg, klen_next;
    logic [29:0]    prev_hdr_reg, prev_hdr_next, prev_len_reg, prev_len_next;
    logic [29:0]    next_hdr_reg, next_hdr_next, next_len_reg, next_len_next;
    logic           prev_vld_reg, prev_vld_next, next_vld_reg, next_vld_next;
    logic [32:0]    end_reg, end_next;
    logic [32:0]    base_reg, base_next;
    logic           skip_reg, skip_next;
    logic [1:0]     status_reg, status_next;
    logic [31:0]    gaddr_reg, gaddr_next;
    logic [29:0]    gwords_reg, gwords_next;
    logic           m_valid_reg, m_valid_next;
    ffea_pkg::rsp_t m_data_reg, m_data_next;

    logic           wr_en, rd_en;
    logic [IW-1:0]  wr_addr, rd_addr;
    logic [59:0]    wr_data, rd_data;

    ffea_ram #(.WIDTH(60), .DEPTH(MAX_EXTENTS)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // entry fields and compares on the read word
    logic [29:0]   e_hdr, e_len;
    logic          fit, split, below, last, full, at_end, at_pos;
    logic          prev_adj, next_adj;
    logic [CW-1:0] idx_inc;
    logic [30:0]   alloc_frag;

    assign e_hdr    = rd_data[59:30];
    assign e_len    = rd_data[29:0];
    assign fit      = {1'b0, e_len} >= want_reg;
    assign split    = {1'b0, e_len} > (want_reg + 31'(ffea_pkg::SPARE_WORDS));
    assign below    = e_hdr < key_reg;
    assign idx_inc  = CW'(idx_reg + 1'b1);
    assign last     = idx_inc == cnt_reg;
    assign full     = cnt_reg == CW'(MAX_EXTENTS);
    assign at_end   = idx_reg == cnt_reg;
    assign at_pos   = idx_reg == pos_reg;
    assign prev_adj = prev_vld_reg &&
        (({1'b0, prev_hdr_reg} + 31'd1 + {1'b0, prev_len_reg}) == {1'b0, key_reg});
    assign next_adj = next_vld_reg &&
        (({1'b0, key_reg} + 31'd1 + {1'b0, klen_reg}) == {1'b0, next_hdr_reg});
    assign alloc_frag = {1'b0, e_hdr} + {1'b0, e_len} - want_reg + 31'd1;

    // request preparation
    logic [29:0] uh;
    logic [30:0] free_end;
    logic [32:0] add_end, add_cut;
    logic [33:0] base_al, base_lim;

    assign uh       = req_reg.address[31:2] - 30'd1;
    assign free_end = {1'b0, uh} + 31'd1 + {1'b0, req_reg.block_words};
    assign add_end  = {1'b0, req_reg.address} + {1'b0, req_reg.size_bytes};
    assign add_cut  = (floor_reg[15:0] != 16'd0) ?
        {({1'b0, floor_reg[31:16]} + 17'd1), 16'd0} : {1'b0, floor_reg};
    assign base_al  = ({1'b0, base_reg} + 34'd3) & ~34'd3;
    assign base_lim = base_al + 34'd8;

    assign s_ready   = state_reg == ffea_pkg::ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ffea_pkg::ST_IDLE: begin
                if (s_valid) state_next = ffea_pkg::ST_PREP;
            end
            ffea_pkg::ST_PREP: begin
                case (req_reg.opcode)
                    ffea_pkg::OP_ALLOC:
                        state_next = (cnt_reg == '0) ? ffea_pkg::ST_DONE : ffea_pkg::ST_RD;
                    ffea_pkg::OP_FREE: begin
                        if (req_reg.address < 32'd4) state_next = ffea_pkg::ST_DONE;
                        else if (cnt_reg == '0)      state_next = ffea_pkg::ST_DEC;
                        else                         state_next = ffea_pkg::ST_RD;
                    end
                    ffea_pkg::OP_ADD: state_next = ffea_pkg::ST_PREP2;
                    default: state_next = ffea_pkg::ST_DONE;
                endcase
            end
            ffea_pkg::ST_PREP2: begin
                if (skip_reg || ({1'b0, end_reg} < base_lim)) state_next = ffea_pkg::ST_DONE;
                else if (cnt_reg == '0) state_next = ffea_pkg::ST_DEC;
                else                    state_next = ffea_pkg::ST_RD;
            end
            ffea_pkg::ST_RD: state_next = ffea_pkg::ST_CHK;
            ffea_pkg::ST_CHK: begin
                if (req_reg.opcode == ffea_pkg::OP_ALLOC) begin
                    if (fit && split) state_next = ffea_pkg::ST_DONE;
                    else if (fit)     state_next = last ? ffea_pkg::ST_DONE : ffea_pkg::ST_SH_RD;
                    else              state_next = last ? ffea_pkg::ST_DONE : ffea_pkg::ST_RD;
                end else begin
                    if (below && !last) state_next = ffea_pkg::ST_RD;
                    else                state_next = ffea_pkg::ST_DEC;
                end
            end
            ffea_pkg::ST_DEC: begin
                if (req_reg.opcode == ffea_pkg::OP_FREE && prev_adj && next_adj)
                    state_next = last ? ffea_pkg::ST_DONE : ffea_pkg::ST_SH_RD;
                else if (req_reg.opcode == ffea_pkg::OP_FREE && (prev_adj || next_adj))
                    state_next = ffea_pkg::ST_DONE;
                else if (full)
                    state_next = ffea_pkg::ST_DONE;
                else
                    state_next = at_end ? ffea_pkg::ST_FIN : ffea_pkg::ST_SH_RD;
            end
            ffea_pkg::ST_SH_RD: state_next = ffea_pkg::ST_SH_WR;
            ffea_pkg::ST_SH_WR: begin
                if (down_reg) state_next = last ? ffea_pkg::ST_DONE : ffea_pkg::ST_SH_RD;
                else          state_next = at_pos ? ffea_pkg::ST_FIN : ffea_pkg::ST_SH_RD;
            end
            ffea_pkg::ST_FIN: state_next = ffea_pkg::ST_DONE;
            ffea_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ffea_pkg::ST_IDLE;
            end
            default: state_next = ffea_pkg::ST_IDLE;
        endcase
    end

    // datapath, table access and result word
    always_comb begin
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        down_next     = down_reg;
        want_next     = want_reg;
        key_next      = key_reg;
        klen_next     = klen_reg;
        prev_hdr_next = prev_hdr_reg;
        prev_len_next = prev_len_reg;
        next_hdr_next = next_hdr_reg;
        next_len_next = next_len_reg;
        prev_vld_next = prev_vld_reg;
        next_vld_next = next_vld_reg;
        end_next      = end_reg;
        base_next     = base_reg;
        skip_next     = skip_reg;
        status_next   = status_reg;
        gaddr_next    = gaddr_reg;
        gwords_next   = gwords_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg[IW-1:0];
        wr_data       = rd_data;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[IW-1:0];
        case (state_reg)
            ffea_pkg::ST_PREP: begin
                status_next   = ffea_pkg::STS_OK;
                gaddr_next    = '0;
                gwords_next   = '0;
                idx_next      = '0;
                prev_vld_next = 1'b0;
                next_vld_next = 1'b0;
                down_next     = 1'b0;
                want_next     = 31'(({1'b0, req_reg.size_bytes} + 33'd3) >> 2);
                key_next      = uh;
                klen_next     = (free_end > 31'h4000_0000) ?
                    (30'h3FFF_FFFF - uh) : req_reg.block_words;
                if (req_reg.opcode == ffea_pkg::OP_ALLOC && cnt_reg == '0)
                    status_next = ffea_pkg::STS_NO_FIT;
                // clip region end, raise base to the cutoff
                end_next  = (add_end > 33'h1_0000_0000) ? 33'h1_0000_0000 : add_end;
                base_next = {1'b0, req_reg.address};
                skip_next = 1'b0;
                if ({1'b0, req_reg.address} < add_cut) begin
                    base_next = add_cut;
                    skip_next = ((add_end > 33'h1_0000_0000) ? 33'h1_0000_0000 : add_end)
                        < add_cut;
                end
            end
            ffea_pkg::ST_PREP2: begin
                key_next  = base_al[31:2];
                klen_next = 30'(({1'b0, end_reg} - base_al - 34'd4) >> 2);
                if (skip_reg || ({1'b0, end_reg} < base_lim))
                    status_next = ffea_pkg::STS_SKIPPED;
            end
            ffea_pkg::ST_RD: begin
                rd_en = 1'b1;
            end
            ffea_pkg::ST_CHK: begin
                if (req_reg.opcode == ffea_pkg::OP_ALLOC) begin
                    if (fit && split) begin
                        // grant taken from the tail
                        wr_en       = 1'b1;
                        wr_data     = {e_hdr, 30'({1'b0, e_len} - want_reg - 31'd1)};
                        gaddr_next  = {alloc_frag[29:0], 2'b00};
                        gwords_next = want_reg[29:0];
                    end else if (fit) begin
                        // whole extent granted, entry removed
                        gaddr_next  = {30'(e_hdr + 30'd1), 2'b00};
                        gwords_next = e_len;
                        down_next   = 1'b1;
                        idx_next    = idx_inc;
                        if (last) cnt_next = CW'(cnt_reg - 1'b1);
                    end else begin
                        idx_next = idx_inc;
                        if (last) status_next = ffea_pkg::STS_NO_FIT;
                    end
                end else begin
                    if (below) begin
                        prev_hdr_next = e_hdr;
                        prev_len_next = e_len;
                        prev_vld_next = 1'b1;
                        idx_next      = idx_inc;
                    end else begin
                        next_hdr_next = e_hdr;
                        next_len_next = e_len;
                        next_vld_next = 1'b1;
                    end
                end
            end
            ffea_pkg::ST_DEC: begin
                pos_next = idx_reg;
                if (req_reg.opcode == ffea_pkg::OP_FREE && prev_adj) begin
                    wr_en   = 1'b1;
                    wr_addr = IW'(idx_reg - 1'b1);
                    if (next_adj) begin
                        wr_data   = {prev_hdr_reg, 30'(prev_len_reg + klen_reg + 30'd2
                            + next_len_reg)};
                        down_next = 1'b1;
                        idx_next  = idx_inc;
                        if (last) cnt_next = CW'(cnt_reg - 1'b1);
                    end else begin
                        wr_data = {prev_hdr_reg, 30'(prev_len_reg + klen_reg + 30'd1)};
                    end
                end else if (req_reg.opcode == ffea_pkg::OP_FREE && next_adj) begin
                    wr_en   = 1'b1;
                    wr_data = {key_reg, 30'(klen_reg + 30'd1 + next_len_reg)};
                end else if (full) begin
                    status_next = ffea_pkg::STS_FULL;
                end else begin
                    // open a slot by shifting the tail up
                    down_next = 1'b0;
                    if (!at_end) idx_next = CW'(cnt_reg - 1'b1);
                end
            end
            ffea_pkg::ST_SH_RD: begin
                rd_en = 1'b1;
            end
            ffea_pkg::ST_SH_WR: begin
                wr_en = 1'b1;
                if (down_reg) begin
                    wr_addr  = IW'(idx_reg - 1'b1);
                    idx_next = idx_inc;
                    if (last) cnt_next = CW'(cnt_reg - 1'b1);
                end else begin
                    wr_addr = idx_inc[IW-1:0];
                    if (!at_pos) idx_next = CW'(idx_reg - 1'b1);
                end
            end
            ffea_pkg::ST_FIN: begin
                wr_en    = 1'b1;
                wr_addr  = pos_reg[IW-1:0];
                wr_data  = {key_reg, klen_reg};
                cnt_next = CW'(cnt_reg + 1'b1);
            end
            ffea_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: status_reg, grant_addr: gaddr_reg,
                                     grant_words: gwords_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffea_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            floor_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) floor_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) req_reg <= s_data;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        down_reg     <= down_next;
        want_reg     <= want_next;
        key_reg      <= key_next;
        klen_reg     <= klen_next;
        prev_hdr_reg <= prev_hdr_next;
        prev_len_reg <= prev_len_next;
        next_hdr_reg <= next_hdr_next;
        next_len_reg <= next_len_next;
        prev_vld_reg <= prev_vld_next;
        next_vld_reg <= next_vld_next;
        end_reg      <= end_next;
        base_reg     <= base_next;
        skip_reg     <= skip_next;
        status_reg   <= status_next;
        gaddr_reg    <= gaddr_next;
        gwords_reg   <= gwords_next;
        m_data_reg   <= m_data_next;
    end

    // result word checks
    logic m_fail, m_nogrant;

    assign m_fail    = m_data.status != ffea_pkg::STS_OK;
    assign m_nogrant = (m_data.grant_addr == '0) && (m_data.grant_words == '0);

    `FFEA_ASSERT(a_cnt_bound, cnt_reg <= CW'(MAX_EXTENTS), "extent count past table depth")
    `FFEA_ASSERT(a_no_grant, (m_valid && m_fail) |-> m_nogrant, "failed request carries a grant")
    `FFEA_ASSERT(a_idle_quiet, s_ready |-> !wr_en, "table written while idle")
    `FFEA_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (s_ready && !m_valid), "busy after reset")

endmodule
